@@ rtl/core/chained_hash_table_unit_macros.svh @@
// assertion macros for the chained hash table unit
// included by modules that check their own control logic
`ifndef CHAINED_HASH_TABLE_UNIT_MACROS_SVH
`define CHAINED_HASH_TABLE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CHT_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define CHT_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define CHT_ASSERT(label, clk, rst, prop)
`define CHT_ASSERT_NR(label, clk, prop)
`endif
`endif

@@ rtl/core/cht_pkg.sv @@
// shared types and codes for the chained hash table unit
// no dependencies
package cht_pkg;
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_GET    = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_REPLACED = 3'd1;
  localparam logic [2:0] ST_FOUND    = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_REMOVED  = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_CLEAR  = 11'b00000000010,
    S_HASH   = 11'b00000000100,
    S_MOD    = 11'b00000001000,
    S_HEAD   = 11'b00000010000,
    S_NODE   = 11'b00000100000,
    S_CHECK  = 11'b00001000000,
    S_FREE   = 11'b00010000000,
    S_INS    = 11'b00100000000,
    S_DONE   = 11'b01000000000,
    S_POP    = 11'b10000000000
  } state_t;
endpackage

@@ rtl/core/cht_bucket_mod.sv @@
// iterative remainder of the key byte sum by the bucket count
// depends on nothing but its ports
module cht_bucket_mod #(
  parameter int SUM_W = 11,
  parameter int BW = 7
) (
  input  logic             clk,
  input  logic             go,
  input  logic [SUM_W-1:0] sum,
  input  logic [BW-1:0]    divisor,
  output logic [SUM_W-1:0] rem,
  output logic             done
);
  localparam int CW = $clog2(SUM_W + 1);
  logic [SUM_W-1:0] acc;
  logic [CW-1:0] cnt;
  logic busy;
  logic [SUM_W:0] trial;
  logic [SUM_W:0] dsh;

  assign dsh = {{(SUM_W+1-BW){1'b0}}, divisor} << cnt;
  assign trial = {1'b0, acc} - dsh;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (go) begin
      acc <= sum;
      cnt <= CW'(SUM_W - 1);
      busy <= 1'b1;
    end else if (busy) begin
      if (!trial[SUM_W] && (dsh >> cnt) == {{(SUM_W+1-BW){1'b0}}, divisor}) begin
        acc <= trial[SUM_W-1:0];
      end
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end
  assign rem = acc;
endmodule

@@ rtl/core/chained_hash_table_unit.sv @@
// chained hash table unit: request sequencer, bucket and node memories
// depends on cht_pkg, cht_bucket_mod and the assertion macro header
//
// usage: pulse start with mode, key, age and major while busy is low; the
// item is taken at that edge and busy rises. one result appears later on
// status, found_age and found_major for one cycle, marked by done. the
// receiver cannot stall. an 11-step remainder unit picks the bucket, then
// each chain node costs one synchronous memory read and one compare. busy
// drops together with done, so the next item can be taken at the edge that
// ends the done cycle. table_size must be written through cfg_we and
// cfg_data only while idle; the block itself does not enforce this. after
// reset, busy stays high while the bucket heads are cleared and the free
// stack is filled, one entry per cycle, over the larger of NODES and
// BUCKETS entries.
`include "chained_hash_table_unit_macros.svh"
module chained_hash_table_unit #(
  parameter int BUCKETS = 64,
  parameter int NODES = 256,
  parameter int KEY_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [63:0] key,
  input  logic [7:0]  age,
  input  logic [63:0] major,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_data,
  output logic        done,
  output logic [2:0]  status,
  output logic [7:0]  found_age,
  output logic [63:0] found_major
);
  localparam int NW = $clog2(NODES);
  localparam int LW = NW + 1;
  localparam int BKW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int BCW = $clog2(BUCKETS + 1);
  localparam int SUM_W = 11;
  localparam int CLR_N = (NODES > BUCKETS) ? NODES : BUCKETS;
  localparam int CLW = $clog2(CLR_N + 1);
  localparam logic [LW-1:0] NIL = LW'(NODES);
  localparam logic [LW-1:0] STEP_MAX = LW'(NODES);

  logic [6:0] table_size;
  cht_pkg::state_t state;

  logic [LW-1:0] head_mem [BUCKETS];
  logic [63:0]   key_mem  [NODES];
  logic [7:0]    age_mem  [NODES];
  logic [63:0]   maj_mem  [NODES];
  logic [LW-1:0] link_mem [NODES];
  logic [NW-1:0] free_mem [NODES];
  logic [LW-1:0] free_count;

  logic [1:0]  r_mode;
  logic [63:0] r_key;
  logic [7:0]  r_age;
  logic [63:0] r_major;
  logic [SUM_W-1:0] sum;
  logic [BKW-1:0] bkt;
  logic [LW-1:0] cur, prev, steps;
  logic [CLW-1:0] clr;
  logic [LW-1:0] head_rd, link_rd;
  logic [63:0] key_rd, maj_rd;
  logic [7:0] age_rd;
  logic [NW-1:0] free_rd;
  logic [6:0] nb;
  logic mod_go, mod_done;
  logic [SUM_W-1:0] mod_rem;
  logic [63:0] mkey;

  always_comb begin
    mkey = key;
    for (int i = KEY_BYTES; i < 8; i++) mkey[i*8 +: 8] = 8'd0;
  end

  always_comb begin
    nb = table_size;
    if (nb == 7'd0) nb = 7'd1;
    if ({{(BCW > 7 ? BCW - 7 : 0){1'b0}}, nb} > BCW'(BUCKETS)) nb = 7'(BUCKETS);
  end

  assign mod_go = (state == cht_pkg::S_HASH);
  cht_bucket_mod #(.SUM_W(SUM_W), .BW(7)) u_mod (
    .clk(clk), .go(mod_go), .sum(sum), .divisor(nb), .rem(mod_rem), .done(mod_done)
  );

  assign busy = (state != cht_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) table_size <= 7'd64;
    else if (cfg_we) table_size <= cfg_data;
  end

  // synchronous memory reads, registered outputs
  always_ff @(posedge clk) begin
    head_rd <= head_mem[bkt];
    key_rd  <= key_mem[cur[NW-1:0]];
    age_rd  <= age_mem[cur[NW-1:0]];
    maj_rd  <= maj_mem[cur[NW-1:0]];
    link_rd <= link_mem[cur[NW-1:0]];
    free_rd <= free_mem[free_count[NW-1:0] - 1'b1];
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= cht_pkg::S_CLEAR;
      clr <= '0;
      free_count <= LW'(NODES);
    end else begin
      case (state)
        cht_pkg::S_CLEAR: begin
          if (clr < CLW'(BUCKETS)) head_mem[clr[BKW-1:0]] <= NIL;
          if (clr < CLW'(NODES)) free_mem[clr[NW-1:0]] <= NW'(NODES - 1) - clr[NW-1:0];
          if (clr == CLW'(CLR_N - 1)) state <= cht_pkg::S_IDLE;
          clr <= clr + 1'b1;
        end
        cht_pkg::S_IDLE: begin
          if (start) begin
            r_mode <= mode;
            r_key <= mkey;
            r_age <= age;
            r_major <= major;
            state <= cht_pkg::S_HASH;
            sum <= SUM_W'(mkey[7:0]) + SUM_W'(mkey[15:8]) + SUM_W'(mkey[23:16])
                 + SUM_W'(mkey[31:24]) + SUM_W'(mkey[39:32]) + SUM_W'(mkey[47:40])
                 + SUM_W'(mkey[55:48]) + SUM_W'(mkey[63:56]);
          end
        end
        cht_pkg::S_HASH: state <= cht_pkg::S_MOD;
        cht_pkg::S_MOD: begin
          if (mod_done) begin
            bkt <= mod_rem[BKW-1:0];
            state <= cht_pkg::S_HEAD;
          end
        end
        cht_pkg::S_HEAD: begin
          state <= cht_pkg::S_POP;
        end
        cht_pkg::S_POP: begin
          cur <= head_rd;
          prev <= NIL;
          steps <= '0;
          state <= cht_pkg::S_NODE;
        end
        cht_pkg::S_NODE: begin
          if (cur >= NIL || steps >= STEP_MAX) begin
            cur <= NIL;
            state <= cht_pkg::S_FREE;
          end else begin
            state <= cht_pkg::S_CHECK;
          end
        end
        cht_pkg::S_CHECK: begin
          if (key_rd == r_key) begin
            state <= cht_pkg::S_FREE;
          end else begin
            prev <= cur;
            cur <= link_rd;
            steps <= steps + 1'b1;
            state <= cht_pkg::S_NODE;
          end
        end
        cht_pkg::S_FREE: begin
          status <= cht_pkg::ST_NOTFOUND;
          found_age <= '0;
          found_major <= '0;
          state <= cht_pkg::S_DONE;
          case (r_mode)
            cht_pkg::MODE_INSERT: begin
              if (cur != NIL) begin
                age_mem[cur[NW-1:0]] <= r_age;
                maj_mem[cur[NW-1:0]] <= r_major;
                status <= cht_pkg::ST_REPLACED;
              end else if (free_count == '0) begin
                status <= cht_pkg::ST_FULL;
              end else begin
                state <= cht_pkg::S_INS;
              end
            end
            cht_pkg::MODE_GET: begin
              if (cur != NIL) begin
                status <= cht_pkg::ST_FOUND;
                found_age <= age_rd;
                found_major <= maj_rd;
              end
            end
            cht_pkg::MODE_REMOVE: begin
              if (cur != NIL) begin
                if (prev == NIL) head_mem[bkt] <= link_rd;
                else link_mem[prev[NW-1:0]] <= link_rd;
                if (free_count < LW'(NODES)) begin
                  free_mem[free_count[NW-1:0]] <= cur[NW-1:0];
                  free_count <= free_count + 1'b1;
                end
                status <= cht_pkg::ST_REMOVED;
              end
            end
            default: ;
          endcase
        end
        cht_pkg::S_INS: begin
          key_mem[free_rd] <= r_key;
          age_mem[free_rd] <= r_age;
          maj_mem[free_rd] <= r_major;
          link_mem[free_rd] <= head_rd;
          head_mem[bkt] <= {1'b0, free_rd};
          free_count <= free_count - 1'b1;
          status <= cht_pkg::ST_INSERTED;
          state <= cht_pkg::S_DONE;
        end
        cht_pkg::S_DONE: begin
          done <= 1'b1;
          state <= cht_pkg::S_IDLE;
        end
        default: state <= cht_pkg::S_IDLE;
      endcase
    end
  end

  `CHT_ASSERT(a_onehot, clk, rst, $onehot(state))
  `CHT_ASSERT(a_free_range, clk, rst, free_count <= LW'(NODES))
  `CHT_ASSERT(a_done_idle, clk, rst, done |-> state == cht_pkg::S_IDLE)
  `CHT_ASSERT(a_status_range, clk, rst, done |-> status <= cht_pkg::ST_FULL)
  `CHT_ASSERT(a_zero_data, clk, rst, (done && status != cht_pkg::ST_FOUND) |-> found_age == '0)
endmodule

@@ dv/tb_chained_hash_table_unit.sv @@
// self-checking testbench for chained_hash_table_unit: directed and random requests
// checked against a behavioral model of the chained table kept inside the bench
// depends on cht_pkg and the chained_hash_table_unit rtl
module tb_chained_hash_table_unit;
  localparam int BUCKETS = 64;
  localparam int NODES = 256;
  localparam logic [8:0] NIL = 9'(NODES);
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  found_age;
    logic [63:0] found_major;
  } lookup_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  mode = '0;
  logic [63:0] key = '0;
  logic [7:0]  age = '0;
  logic [63:0] major = '0;
  logic        cfg_we = 1'b0;
  logic [6:0]  cfg_data = '0;
  logic        done;
  logic [2:0]  status;
  logic [7:0]  found_age;
  logic [63:0] found_major;

  lookup_result_t expected_results[$];
  int mismatches = 0;
  bit gaps_on = 1'b1;

  logic [8:0]  chain_head [BUCKETS];
  logic [63:0] node_key_m [NODES];
  logic [7:0]  node_age_m [NODES];
  logic [63:0] node_major_m [NODES];
  logic [8:0]  node_link_m [NODES];
  logic [7:0]  free_nodes [NODES];
  int          free_left;
  logic [6:0]  buckets_cfg;

  chained_hash_table_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode), .key(key),
    .age(age), .major(major), .cfg_we(cfg_we), .cfg_data(cfg_data), .done(done),
    .status(status), .found_age(found_age), .found_major(found_major)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 4000000);
    $display("Some tests failed");
    $finish;
  end

  function automatic int bucket_of_key(logic [63:0] k);
    int sum;
    int n;
    sum = 0;
    for (int i = 0; i < 8; i++) sum += k[8*i +: 8];
    n = (buckets_cfg == 0) ? 1 : ((buckets_cfg > BUCKETS) ? BUCKETS : buckets_cfg);
    return sum % n;
  endfunction

  function automatic lookup_result_t table_lookup(logic [1:0] m, logic [63:0] k,
                                                  logic [7:0] a, logic [63:0] mj);
    int b;
    int steps;
    logic [8:0] cur;
    logic [8:0] prev;
    logic [7:0] n;
    lookup_result_t r;
    b = bucket_of_key(k);
    cur = chain_head[b];
    prev = NIL;
    steps = 0;
    r = '{cht_pkg::ST_NOTFOUND, 8'd0, 64'd0};
    while (cur < NIL && steps < NODES) begin
      if (node_key_m[cur] == k) break;
      prev = cur;
      cur = node_link_m[cur];
      steps++;
    end
    if (steps >= NODES) cur = NIL;
    case (m)
      cht_pkg::MODE_INSERT: begin
        if (cur != NIL) begin
          node_age_m[cur] = a;
          node_major_m[cur] = mj;
          r.status = cht_pkg::ST_REPLACED;
        end else if (free_left == 0) begin
          r.status = cht_pkg::ST_FULL;
        end else begin
          free_left--;
          n = free_nodes[free_left];
          node_key_m[n] = k;
          node_age_m[n] = a;
          node_major_m[n] = mj;
          node_link_m[n] = chain_head[b];
          chain_head[b] = {1'b0, n};
          r.status = cht_pkg::ST_INSERTED;
        end
      end
      cht_pkg::MODE_GET: begin
        if (cur != NIL) r = '{cht_pkg::ST_FOUND, node_age_m[cur], node_major_m[cur]};
      end
      cht_pkg::MODE_REMOVE: begin
        if (cur != NIL) begin
          if (prev == NIL) chain_head[b] = node_link_m[cur];
          else node_link_m[prev] = node_link_m[cur];
          free_nodes[free_left] = cur[7:0];
          free_left++;
          r.status = cht_pkg::ST_REMOVED;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_item(logic [1:0] m, logic [63:0] k, logic [7:0] a, logic [63:0] mj);
    lookup_result_t predicted;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    start <= 1'b1;
    mode <= m;
    key <= k;
    age <= a;
    major <= mj;
    do @(posedge clk); while (busy);
    predicted = table_lookup(m, k, a, mj);
    expected_results = {expected_results, predicted};
  endtask

  task automatic drain;
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    do @(posedge clk); while (busy);
  endtask

  task automatic write_size(logic [6:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    buckets_cfg = v;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: status %0d", status);
      end else begin
        lookup_result_t e;
        e = expected_results.pop_front();
        if (e.status !== status || e.found_age !== found_age ||
            e.found_major !== found_major) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d/%h/%h got %0d/%h/%h", e.status,
                     e.found_age, e.found_major, status, found_age, found_major);
        end
      end
    end
  end

  task automatic test_basic_ops;
    send_item(cht_pkg::MODE_GET, 64'd0, 8'd0, 64'd0);
    send_item(cht_pkg::MODE_INSERT, 64'd0, 8'd0, 64'd0);
    send_item(cht_pkg::MODE_GET, 64'd0, 8'd7, 64'd5);
    send_item(cht_pkg::MODE_INSERT, '1, 8'hff, '1);
    send_item(cht_pkg::MODE_GET, '1, 8'd0, 64'd0);
    send_item(cht_pkg::MODE_INSERT, 64'd0, 8'hff, '1);
    send_item(cht_pkg::MODE_GET, 64'd0, 8'd0, 64'd0);
    send_item(cht_pkg::MODE_REMOVE, 64'h1234, 8'd0, 64'd0);
    send_item(MODE_UNUSED, 64'd0, 8'h55, 64'h1);
    send_item(cht_pkg::MODE_GET, 64'd0, 8'd0, 64'd0);
    send_item(cht_pkg::MODE_REMOVE, 64'd0, 8'd0, 64'd0);
    send_item(cht_pkg::MODE_GET, 64'd0, 8'd0, 64'd0);
    send_item(cht_pkg::MODE_REMOVE, 64'd0, 8'd0, 64'd0);
  endtask

  task automatic test_chain_unlink;
    write_size(7'd1);
    send_item(cht_pkg::MODE_INSERT, 64'h01, 8'd1, 64'h11);
    send_item(cht_pkg::MODE_INSERT, 64'h0100, 8'd2, 64'h22);
    send_item(cht_pkg::MODE_INSERT, 64'h010000, 8'd3, 64'h33);
    send_item(cht_pkg::MODE_REMOVE, 64'h0100, 8'd0, 64'd0);
    send_item(cht_pkg::MODE_GET, 64'h01, 8'd0, 64'd0);
    send_item(cht_pkg::MODE_GET, 64'h010000, 8'd0, 64'd0);
    send_item(cht_pkg::MODE_REMOVE, 64'h010000, 8'd0, 64'd0);
    send_item(cht_pkg::MODE_GET, 64'h01, 8'd0, 64'd0);
    send_item(cht_pkg::MODE_REMOVE, 64'h01, 8'd0, 64'd0);
    send_item(cht_pkg::MODE_GET, 64'h01, 8'd0, 64'd0);
  endtask

  task automatic test_table_sizes;
    write_size(7'd0);
    send_item(cht_pkg::MODE_INSERT, 64'h0203, 8'd9, 64'h99);
    send_item(cht_pkg::MODE_GET, 64'h0203, 8'd0, 64'd0);
    write_size(7'd127);
    send_item(cht_pkg::MODE_INSERT, 64'h7f7f, 8'd4, 64'hcafe);
    send_item(cht_pkg::MODE_GET, 64'h7f7f, 8'd0, 64'd0);
    write_size(7'd5);
    send_item(cht_pkg::MODE_GET, 64'h7f7f, 8'd0, 64'd0);
    send_item(cht_pkg::MODE_INSERT, 64'h7f7f, 8'd6, 64'hbeef);
    write_size(7'd64);
    send_item(cht_pkg::MODE_GET, 64'h7f7f, 8'd0, 64'd0);
    send_item(cht_pkg::MODE_REMOVE, 64'h7f7f, 8'd0, 64'd0);
  endtask

  task automatic test_pool_full;
    int filled;
    write_size(7'd64);
    filled = 0;
    while (free_left > 0) begin
      send_item(cht_pkg::MODE_INSERT, {32'ha5a5_0000, 32'(filled)}, 8'(filled),
                {$urandom, $urandom});
      filled++;
    end
    send_item(cht_pkg::MODE_INSERT, 64'hdead, 8'd1, 64'd1);
    send_item(cht_pkg::MODE_INSERT, 64'hbeef, 8'd2, 64'd2);
    send_item(cht_pkg::MODE_INSERT, {32'ha5a5_0000, 32'd0}, 8'd77, 64'd77);
    send_item(cht_pkg::MODE_GET, {32'ha5a5_0000, 32'd0}, 8'd0, 64'd0);
    for (int i = 0; i < filled; i++)
      send_item(cht_pkg::MODE_REMOVE, {32'ha5a5_0000, 32'(i)}, 8'd0, 64'd0);
  endtask

  task automatic test_random_traffic;
    logic [6:0] sizes [6];
    logic [63:0] keys [32];
    logic [63:0] k;
    logic [1:0] m;
    int r;
    sizes = '{7'd64, 7'd1, 7'd127, 7'($urandom_range(1, 64)), 7'd0, 7'd3};
    for (int p = 0; p < 6; p++) begin
      write_size(sizes[p]);
      gaps_on = (p < 5);
      for (int i = 0; i < 32; i++) keys[i] = {$urandom, $urandom};
      for (int i = 0; i < 140; i++) begin
        r = $urandom_range(0, 99);
        m = (r < 45) ? cht_pkg::MODE_INSERT : (r < 75) ? cht_pkg::MODE_GET :
            (r < 95) ? cht_pkg::MODE_REMOVE : MODE_UNUSED;
        k = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : keys[$urandom_range(0, 31)];
        send_item(m, k, 8'($urandom), {$urandom, $urandom});
      end
    end
  endtask

  initial begin
    for (int i = 0; i < BUCKETS; i++) chain_head[i] = NIL;
    for (int i = 0; i < NODES; i++) begin
      node_link_m[i] = NIL;
      free_nodes[i] = 8'(NODES - 1 - i);
    end
    free_left = NODES;
    buckets_cfg = 7'd64;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_basic_ops();
    test_chain_unlink();
    test_table_sizes();
    test_pool_full();
    test_random_traffic();
    drain();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/cht_pkg.sv
rtl/core/cht_bucket_mod.sv
rtl/core/chained_hash_table_unit.sv
dv/tb_chained_hash_table_unit.sv
